### design/cubic_bezier_point_evaluator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier point evaluator
// Concurrent checks that are compiled in for simulation and left out for
// synthesis. The macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_CORE_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define CBPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define CBPE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CBPE_ASSERT(lbl, prop, msg)
`define CBPE_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

### design/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator package
// Default sizes, sequencer codes, command codes and the state type shared
// by the evaluator core.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  // Default sizes of the point store and of the fixed-point formats.
  localparam int POINT_SLOTS_DEF     = 8;
  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // Point index field width, fixed by the word layout.
  localparam int IDX_BITS = 3;

  // Bit positions in the input tuser.
  localparam int TUSER_CMD = 0;
  localparam int TUSER_SEL = 1;
  localparam int TUSER_W   = 2;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Sequencer step width and the operations of the shared multiplier.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] OP_TT       = 5'd0;   // t * t        -> st
  localparam logic [STEP_W-1:0] OP_UU       = 5'd1;   // u * u        -> su
  localparam logic [STEP_W-1:0] OP_ST_T     = 5'd2;   // st * t       -> w3
  localparam logic [STEP_W-1:0] OP_SU_U     = 5'd3;   // su * u       -> w0
  localparam logic [STEP_W-1:0] OP_T_SU     = 5'd4;   // 3t * su      -> w1
  localparam logic [STEP_W-1:0] OP_ST_U     = 5'd5;   // st * 3u      -> w2
  localparam logic [STEP_W-1:0] OP_PT_FIRST = 5'd6;   // first point product
  localparam logic [STEP_W-1:0] OP_COUNT    = 5'd18;  // number of operations
  localparam logic [STEP_W-1:0] STEP_FINAL  = 5'd19;  // rounding of the last sum
  localparam logic [STEP_W-1:0] STEP_WGT_READY = 5'd7; // all weights registered

  // Coordinate codes.
  localparam logic [1:0] COORD_X = 2'd0;
  localparam logic [1:0] COORD_Y = 2'd1;
  localparam logic [1:0] COORD_Z = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

### design/cubic_bezier_point_evaluator_core.sv
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator core
// Holds two cubic curves of 3D control points and evaluates one point of a
// curve per evaluate word with a single shared multiplier.
// ----------------------------------------------------------------------------
// A write word (tuser command 0) stores one control point. An evaluate word
// (command 1) keeps the input stalled until its result is in the output
// register: one multiplier issues 18 operations in turn (six for the Bernstein
// weights, twelve for the weighted coordinates), each product passes through
// the multiplier's output register before it is summed, the last sum is rounded,
// the result moves to the output register and the next word is taken in the
// cycle after that. The result waits there while the next word is accepted; if
// it has still not been taken when the following result is ready, the core
// holds that result and keeps its input stalled until the output register
// frees. The point store resets to zero; t above 1.0 is treated as 1.0 and
// results saturate.

`include "cubic_bezier_point_evaluator_core_defines.svh"

module cubic_bezier_point_evaluator_core
  import cbpe_pkg::*;
#(
  parameter int POINT_SLOTS     = POINT_SLOTS_DEF,
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // Input channel.
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: point_index, point_x, point_y, point_z, param_t, zero fill
  input  logic [((3*COORD_BITS+PARAM_FRAC_BITS+4+7)/8)*8-1:0] in_tdata,
  // tuser from bit 0: command, curve_select
  input  logic [TUSER_W-1:0] in_tuser,
  // Result channel.
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: curve_x, curve_y, curve_z, zero fill
  output logic [((3*COORD_BITS+7)/8)*8-1:0] out_tdata
);

  // Widths and constants.
  localparam int C          = COORD_BITS;
  localparam int F          = PARAM_FRAC_BITS;
  localparam int SLOT_W     = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
  localparam int T3_W       = F + 3;
  localparam int MUL_W      = ((C > T3_W) ? C : T3_W) + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = C + F + 3;
  localparam int SUM_W      = ACC_W + 1;
  localparam int Q_W        = SUM_W - F;
  localparam int OUT_DATA_W = ((3*C+7)/8)*8;
  localparam int X_LSB      = IDX_BITS;
  localparam int Y_LSB      = IDX_BITS + C;
  localparam int Z_LSB      = IDX_BITS + 2*C;
  localparam int T_LSB      = IDX_BITS + 3*C;
  localparam int WGT_TOL    = 8;

  localparam logic [F:0] T_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] T_HALF = {2'b01, {(F-1){1'b0}}};
  localparam longint COORD_MAX_L = (longint'(1) <<< (C-1)) - 1;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(COORD_MAX_L);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-COORD_MAX_L - 1);

  // Sequencer and operands.
  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic              sel_r;
  logic [F:0]        t_r, u_r, st_r, su_r;
  logic [T3_W-1:0]   t3_r, u3_r;
  logic [F:0]        w_r [4];

  // Point store.
  logic signed [C-1:0] pt_x_r [POINT_SLOTS];
  logic signed [C-1:0] pt_y_r [POINT_SLOTS];
  logic signed [C-1:0] pt_z_r [POINT_SLOTS];

  // Multiplier and accumulator.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] product_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [C-1:0]      res_r [3];

  // Output register.
  logic          out_valid_r;
  logic [C-1:0]  out_x_r, out_y_r, out_z_r;

  // Control decode.
  logic in_acc, in_eval, out_free;
  logic run_issue, run_consume, fin_last, out_load;

  // Input word fields.
  logic [IDX_BITS-1:0] in_idx;
  logic [F:0]          in_t, t_clamp;
  logic [4:0]          wr_slot;

  assign in_idx  = in_tdata[IDX_BITS-1:0];
  assign in_t    = in_tdata[T_LSB +: F+1];
  assign t_clamp = (in_t > T_ONE) ? T_ONE : in_t;
  assign wr_slot = 5'(in_idx);
  assign in_acc  = in_tvalid && in_tready;
  assign in_eval = in_tuser[TUSER_CMD] == CMD_EVAL;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_eval) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_FINAL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready   = 1'b0;
    run_issue   = 1'b0;
    run_consume = 1'b0;
    fin_last    = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_RUN: begin
        run_issue   = step_r < OP_COUNT;
        run_consume = (step_r != '0) && (step_r <= OP_COUNT);
        fin_last    = step_r == STEP_FINAL;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) begin
        step_r <= step_r + 5'd1;
      end else begin
        step_r <= '0;
      end
    end
  end

  // Parameter registers: loaded on an evaluate word, 3t and 3u at step zero.
  always_ff @(posedge clk) begin
    if (in_acc && in_eval) begin
      sel_r <= in_tuser[TUSER_SEL];
      t_r   <= t_clamp;
      u_r   <= T_ONE - t_clamp;
    end
    if (run_issue && step_r == OP_TT) begin
      t3_r <= T3_W'({t_r, 1'b0}) + T3_W'(t_r);
      u3_r <= T3_W'({u_r, 1'b0}) + T3_W'(u_r);
    end
  end

  // Point store writes; a slot beyond the store is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POINT_SLOTS; i++) begin
        pt_x_r[i] <= '0;
        pt_y_r[i] <= '0;
        pt_z_r[i] <= '0;
      end
    end else if (in_acc && !in_eval && wr_slot < 5'(POINT_SLOTS)) begin
      pt_x_r[wr_slot[SLOT_W-1:0]] <= in_tdata[X_LSB +: C];
      pt_y_r[wr_slot[SLOT_W-1:0]] <= in_tdata[Y_LSB +: C];
      pt_z_r[wr_slot[SLOT_W-1:0]] <= in_tdata[Z_LSB +: C];
    end
  end

  // Operand selection for the operation issued in this step.
  logic [STEP_W-1:0]   iss_k;
  logic [1:0]          iss_c, iss_i;
  logic [4:0]          rd_slot;
  logic signed [C-1:0] pt_coord;

  assign iss_k   = step_r - OP_PT_FIRST;
  assign iss_c   = iss_k[3:2];
  assign iss_i   = iss_k[1:0];
  assign rd_slot = 5'({sel_r, iss_i});

  always_comb begin
    pt_coord = '0;
    if (rd_slot < 5'(POINT_SLOTS)) begin
      unique case (iss_c)
        COORD_X: pt_coord = pt_x_r[rd_slot[SLOT_W-1:0]];
        COORD_Y: pt_coord = pt_y_r[rd_slot[SLOT_W-1:0]];
        default: pt_coord = pt_z_r[rd_slot[SLOT_W-1:0]];
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      OP_TT: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(t_r);
      end
      OP_UU: begin
        mul_a = MUL_W'(u_r);
        mul_b = MUL_W'(u_r);
      end
      OP_ST_T: begin
        mul_a = MUL_W'(st_r);
        mul_b = MUL_W'(t_r);
      end
      OP_SU_U: begin
        mul_a = MUL_W'(su_r);
        mul_b = MUL_W'(u_r);
      end
      OP_T_SU: begin
        mul_a = MUL_W'(t3_r);
        mul_b = MUL_W'(su_r);
      end
      OP_ST_U: begin
        mul_a = MUL_W'(st_r);
        mul_b = MUL_W'(u3_r);
      end
      default: begin
        mul_a = MUL_W'(pt_coord);
        mul_b = MUL_W'(w_r[iss_i]);
      end
    endcase
  end

  // The shared multiplier, registered at its output.
  always_ff @(posedge clk) begin
    if (run_issue) begin
      product_r <= mul_a * mul_b;
    end
  end

  // Decode of the operation whose product is registered now.
  logic [STEP_W-1:0] cons_step, cons_k;
  logic [1:0]        cons_c, cons_i;
  logic [PROD_W-1:0] rnd_full;
  logic [F:0]        rnd_w;
  logic signed [ACC_W-1:0] prod_acc;

  assign cons_step = step_r - 5'd1;
  assign cons_k    = cons_step - OP_PT_FIRST;
  assign cons_c    = cons_k[3:2];
  assign cons_i    = cons_k[1:0];
  assign rnd_full  = product_r + PROD_W'(T_HALF);
  assign rnd_w     = rnd_full[F +: F+1];
  assign prod_acc  = product_r[ACC_W-1:0];

  // Rounded weights and squares.
  always_ff @(posedge clk) begin
    if (run_consume) begin
      unique case (cons_step)
        OP_TT:   st_r   <= rnd_w;
        OP_UU:   su_r   <= rnd_w;
        OP_ST_T: w_r[3] <= rnd_w;
        OP_SU_U: w_r[0] <= rnd_w;
        OP_T_SU: w_r[1] <= rnd_w;
        OP_ST_U: w_r[2] <= rnd_w;
        default: ;
      endcase
    end
  end

  // Rounding half up and saturation of a finished sum.
  logic signed [SUM_W-1:0] fin_sum;
  logic signed [Q_W-1:0]   fin_q;
  logic signed [C-1:0]     fin_sat;

  assign fin_sum = SUM_W'(acc_r) + SUM_W'(T_HALF);
  assign fin_q   = fin_sum[SUM_W-1:F];

  always_comb begin
    priority if (fin_q > Q_MAX) begin
      fin_sat = Q_MAX[C-1:0];
    end else if (fin_q < Q_MIN) begin
      fin_sat = Q_MIN[C-1:0];
    end else begin
      fin_sat = fin_q[C-1:0];
    end
  end

  // Accumulation: the first product of a coordinate restarts the sum.
  always_comb begin
    acc_nxt = acc_r;
    if (run_consume && cons_step >= OP_PT_FIRST) begin
      if (cons_i == 2'd0) begin
        acc_nxt = prod_acc;
      end else begin
        acc_nxt = acc_r + prod_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (run_consume && cons_step >= OP_PT_FIRST && cons_i == 2'd0 && cons_c != COORD_X) begin
      res_r[cons_c - 2'd1] <= fin_sat;
    end
    if (fin_last) begin
      res_r[COORD_Z] <= fin_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= res_r[COORD_X];
      out_y_r <= res_r[COORD_Y];
      out_z_r <= res_r[COORD_Z];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_z_r, out_y_r, out_x_r});

  // Checks on the sequencer and the arithmetic.
  logic [F+2:0] wgt_sum;
  logic [F+1:0] tu_sum;
  logic         eval_acc, run_first, tu_ok, wgt_check, wgt_ok;

  assign wgt_sum = (F+3)'(w_r[0]) + (F+3)'(w_r[1]) + (F+3)'(w_r[2]) + (F+3)'(w_r[3]);
  assign tu_sum  = (F+2)'(t_r) + (F+2)'(u_r);

  assign eval_acc  = in_acc && in_eval;
  assign run_first = (state_r == ST_RUN) && (step_r == '0);
  assign tu_ok     = tu_sum == (F+2)'(T_ONE);
  assign wgt_check = (state_r == ST_RUN) && (step_r == STEP_WGT_READY);
  assign wgt_ok    = (wgt_sum + (F+3)'(WGT_TOL) >= (F+3)'(T_ONE)) &&
                     (wgt_sum <= (F+3)'(T_ONE) + (F+3)'(WGT_TOL));

  `CBPE_ASSERT(a_eval_starts, eval_acc |=> run_first, "evaluate word did not start the sequencer")
  `CBPE_ASSERT(a_t_u_sum, (state_r == ST_RUN) |-> tu_ok, "t and 1-t do not sum to one")
  `CBPE_ASSERT(a_weight_sum, wgt_check |-> wgt_ok, "Bernstein weights do not sum to one")
  `CBPE_ASSERT(a_done_loads, out_load |=> (out_tvalid && state_r == ST_IDLE), "result not presented")

endmodule
